// ===== rtl/core/sbr_pkg.sv =====
// sbr_pkg: shared register index constants for the scope bar resampler.
// No dependencies.
`default_nettype none
package sbr_pkg;
    localparam logic [2:0] REG_WINDOW_LEN  = 3'd0;
    localparam logic [2:0] REG_AREA_X      = 3'd1;
    localparam logic [2:0] REG_AREA_Y      = 3'd2;
    localparam logic [2:0] REG_AREA_WIDTH  = 3'd3;
    localparam logic [2:0] REG_AREA_HEIGHT = 3'd4;
    localparam logic [2:0] REG_BAR_WIDTH   = 3'd5;
    localparam logic [2:0] REG_BAR_SPACING = 3'd6;
    localparam logic [2:0] REG_MODE        = 3'd7;
endpackage
`default_nettype wire

// ===== rtl/core/sbr_ram.sv =====
// sbr_ram: generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module sbr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/sbr_div.sv =====
// sbr_div: restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
`default_nettype none
module sbr_div #(
    parameter int NW = 20,
    parameter int DW = 13
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          go,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic      [NW-1:0] quo,
    output logic      [DW-1:0] rem
);
    localparam int CW = $clog2(NW + 1);
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic [NW-1:0] q_reg;
    logic [DW:0]   r_reg;
    logic [DW-1:0] d_reg;
    logic [DW:0]   trial;

    always_comb
    begin
        trial = {r_reg[DW-1:0], q_reg[NW-1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
            done    <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(NW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg <= 1'b0;
                    done    <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_reg <= trial - {1'b0, d_reg};
                q_reg <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= trial;
                q_reg <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign quo = q_reg;
    assign rem = r_reg[DW-1:0];
endmodule
`default_nettype wire

// ===== rtl/core/scope_bar_resampler.sv =====
// scope_bar_resampler: bar-style audio scope over a circular sample memory.
// Depends on sbr_pkg, sbr_ram, sbr_div.
// A sample word is written to memory in S_WR, with busy high. A frame_end word
// with a nonzero pitch also runs the bar count division. It then emits up to
// MAX_BARS bars, area width over bar pitch. A bar uses the shared serial divider
// at most twice, once for the window index and once for the interpolation, and
// does two memory reads. A single-point bar skips the index division, and a bar
// with a zero remainder skips the interpolation division.
// Bars leave on a one-cycle strobe; the receiver cannot stall.
`default_nettype none
module scope_bar_resampler #(
    parameter int MAX_WINDOW = 4096,
    parameter int MAX_BARS   = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [15:0] sample,
    input  wire logic               frame_end,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [12:0]        cfg_data,
    output logic                    strobe,
    output logic [5:0]              bar_index,
    output logic signed [15:0]      level,
    output logic [12:0]             left,
    output logic [12:0]             right,
    output logic [12:0]             top,
    output logic [13:0]             bottom,
    output logic                    last_bar
);
    localparam int AW = $clog2(MAX_WINDOW);
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int NW = (CW + 6 > 22) ? CW + 6 : 22;

    localparam logic [3:0] S_IDLE = 4'd0, S_WR = 4'd1, S_CNT = 4'd2, S_CNTW = 4'd3,
        S_BAR = 4'd4, S_IDXW = 4'd5, S_RDA = 4'd6, S_RDB = 4'd7, S_RDBW = 4'd8,
        S_INT = 4'd9, S_INTW = 4'd10, S_OUT = 4'd11;

    logic [3:0]  state_reg;
    logic [12:0] window_len_reg;
    logic [11:0] area_x_reg, area_y_reg, area_width_reg, area_height_reg;
    logic [7:0]  bar_width_reg, bar_spacing_reg;
    logic [1:0]  mode_reg;
    logic [AW-1:0] wp_reg;
    logic [CW-1:0] rc_reg;
    logic signed [15:0] sample_reg;
    logic        fe_reg;
    logic [6:0]  count_reg;
    logic [5:0]  i_reg;
    logic [CW-1:0] w_reg;
    logic [CW-1:0] idx_reg;
    logic [12:0] rem_reg;
    logic signed [15:0] a_reg, lvl_reg;
    logic signed [15:0] b_val;
    logic        neg_reg;

    logic          div_go, div_done;
    logic [NW-1:0] div_num, div_quo;
    logic [12:0]   div_den, div_rem;
    logic [AW-1:0] raddr;
    logic [15:0]   rdata;
    logic [8:0]    pitch;
    logic [CW-1:0] k_sel, age;
    logic          miss;
    logic signed [16:0] diff;
    logic signed [29:0] prod_reg;
    logic [29:0]   mag;

    assign cfg_ready = 1'b1;
    assign busy = (state_reg != S_IDLE);
    assign pitch = {1'b0, bar_width_reg} + {1'b0, bar_spacing_reg};

    sbr_div #(.NW(NW), .DW(13)) u_div (
        .clk(clk), .rst_n(rst_n), .go(div_go), .num(div_num), .den(div_den),
        .done(div_done), .quo(div_quo), .rem(div_rem)
    );

    sbr_ram #(.WIDTH(16), .DEPTH(MAX_WINDOW)) u_ram (
        .clk(clk), .we(state_reg == S_WR), .waddr(wp_reg), .wdata(sample_reg),
        .raddr(raddr), .rdata(rdata)
    );

    always_comb
    begin
        k_sel = (state_reg == S_RDB) ? idx_reg + 1'b1 : idx_reg;
        age   = w_reg - 1'b1 - k_sel;
        miss  = (age >= rc_reg);
        raddr = wp_reg - AW'(1) - age[AW-1:0];
    end

    always_comb
    begin
        b_val = (idx_reg + 1'b1 >= w_reg) ? a_reg
                : (neg_reg ? 16'sd0 : $signed(rdata));
    end

    assign diff = 17'(b_val) - 17'(a_reg);
    assign mag = prod_reg[29] ? 30'(-prod_reg) : 30'(prod_reg);

    always_comb
    begin
        div_go  = 1'b0;
        div_num = '0;
        div_den = 13'd1;
        unique case (state_reg)
            S_CNT:
            begin
                div_go = 1'b1;
                div_num = NW'(area_width_reg);
                div_den = 13'(pitch);
            end
            S_BAR:
            begin
                div_go = !(w_reg == CW'(1) || count_reg == 7'd1);
                div_num = NW'(i_reg) * NW'(w_reg - 1'b1);
                div_den = 13'(count_reg - 1'b1);
            end
            S_INT:
            begin
                div_go = 1'b1;
                div_num = NW'(mag[29:0] + (prod_reg[29] ? 30'(count_reg - 2'd2) : 30'd0));
                div_den = 13'(count_reg - 1'b1);
            end
            default:
            begin
            end
        endcase
    end

    logic [12:0] centre, target, lft, tp;
    logic [13:0] btm;
    logic [29:0] hprod;
    logic [16:0] inv;
    assign inv = 17'sd32768 - 17'(lvl_reg);
    assign hprod = 30'(area_height_reg) * 30'(inv);
    assign target = 13'(area_y_reg) + 13'(hprod[29:16]);
    assign centre = 13'(area_y_reg) + 13'(area_height_reg[11:1]);

    always_comb
    begin
        if (mode_reg[0])
        begin
            tp  = (target < centre) ? target : centre;
            btm = 14'((target > centre) ? target : centre);
        end
        else
        begin
            tp  = target;
            btm = 14'(target) + 14'(bar_width_reg);
        end
        if (mode_reg[1])
            lft = 13'(area_x_reg) + 13'(area_width_reg) - 13'(bar_width_reg)
                - 13'(13'(i_reg) * 13'(pitch));
        else
            lft = 13'(area_x_reg) + 13'(13'(i_reg) * 13'(pitch));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg  <= 13'd1024;
            area_x_reg      <= '0;
            area_y_reg      <= '0;
            area_width_reg  <= 12'd320;
            area_height_reg <= 12'd240;
            bar_width_reg   <= 8'd4;
            bar_spacing_reg <= 8'd1;
            mode_reg        <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sbr_pkg::REG_WINDOW_LEN:  window_len_reg  <= cfg_data;
                sbr_pkg::REG_AREA_X:      area_x_reg      <= cfg_data[11:0];
                sbr_pkg::REG_AREA_Y:      area_y_reg      <= cfg_data[11:0];
                sbr_pkg::REG_AREA_WIDTH:  area_width_reg  <= cfg_data[11:0];
                sbr_pkg::REG_AREA_HEIGHT: area_height_reg <= cfg_data[11:0];
                sbr_pkg::REG_BAR_WIDTH:   bar_width_reg   <= cfg_data[7:0];
                sbr_pkg::REG_BAR_SPACING: bar_spacing_reg <= cfg_data[7:0];
                sbr_pkg::REG_MODE:        mode_reg        <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wp_reg    <= '0;
            rc_reg    <= '0;
            strobe    <= 1'b0;
        end
        else
        begin
            strobe <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (start)
                    begin
                        sample_reg <= sample;
                        fe_reg     <= frame_end;
                        state_reg  <= S_WR;
                    end
                S_WR:
                begin
                    wp_reg <= wp_reg + 1'b1;
                    if (rc_reg < CW'(MAX_WINDOW))
                        rc_reg <= rc_reg + 1'b1;
                    if (window_len_reg == 13'd0)
                        w_reg <= CW'(1);
                    else if (32'(window_len_reg) > MAX_WINDOW)
                        w_reg <= CW'(MAX_WINDOW);
                    else
                        w_reg <= CW'(window_len_reg);
                    state_reg <= (fe_reg && pitch != 9'd0) ? S_CNT : S_IDLE;
                end
                S_CNT:
                    state_reg <= S_CNTW;
                S_CNTW:
                    if (div_done)
                    begin
                        i_reg <= '0;
                        if (div_quo == '0)
                            state_reg <= S_IDLE;
                        else
                        begin
                            count_reg <= (div_quo > NW'(MAX_BARS)) ? 7'(MAX_BARS)
                                : 7'(div_quo);
                            state_reg <= S_BAR;
                        end
                    end
                S_BAR:
                    if (div_go)
                        state_reg <= S_IDXW;
                    else
                    begin
                        idx_reg   <= '0;
                        rem_reg   <= '0;
                        state_reg <= S_RDA;
                    end
                S_IDXW:
                    if (div_done)
                    begin
                        idx_reg   <= CW'(div_quo);
                        rem_reg   <= div_rem;
                        state_reg <= S_RDA;
                    end
                S_RDA:
                begin
                    neg_reg   <= miss;
                    state_reg <= S_RDB;
                end
                S_RDB:
                begin
                    a_reg     <= neg_reg ? 16'sd0 : $signed(rdata);
                    neg_reg   <= miss || (idx_reg + 1'b1 >= w_reg);
                    state_reg <= S_RDBW;
                end
                S_RDBW:
                begin
                    if (rem_reg == '0)
                    begin
                        lvl_reg   <= a_reg;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_INT;
                    end
                end
                S_INT:
                begin
                    state_reg <= S_INTW;
                end
                S_INTW:
                    if (div_done)
                    begin
                        lvl_reg <= 16'(17'(a_reg) + (neg_reg ? -17'(div_quo) : 17'(div_quo)));
                        state_reg <= S_OUT;
                    end
                S_OUT:
                begin
                    strobe    <= 1'b1;
                    bar_index <= i_reg;
                    level     <= lvl_reg;
                    left      <= lft;
                    right     <= lft + 13'(bar_width_reg);
                    top       <= tp;
                    bottom    <= btm;
                    last_bar  <= (7'(i_reg) + 1'b1 == count_reg);
                    i_reg     <= i_reg + 1'b1;
                    state_reg <= (7'(i_reg) + 1'b1 == count_reg) ? S_IDLE : S_BAR;
                end
                default: state_reg <= S_IDLE;
            endcase
            if (state_reg == S_RDBW && rem_reg != '0)
            begin
                prod_reg <= 30'(diff) * 30'($signed({1'b0, rem_reg}));
            end
            if (state_reg == S_INT)
            begin
                neg_reg <= prod_reg[29];
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy || $past(state_reg) == S_OUT)
        else $error("bar strobe outside frame");
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last_bar |=> busy)
        else $error("frame ended before last bar");
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word not taken");
endmodule
`default_nettype wire

// ===== tb/tb_scope_bar_resampler.sv =====
// tb_scope_bar_resampler: self-checking bench for the scope bar resampler.
// Depends on sbr_pkg and scope_bar_resampler; predicts every bar from its own
// copy of the sample store and registers and compares each strobed bar in order.
module tb_scope_bar_resampler;
    typedef struct {
        logic signed [15:0] smp;
        logic               fe;
    } word_t;

    typedef struct {
        logic [5:0]         idx;
        logic signed [15:0] lvl;
        logic [12:0]        lft;
        logic [12:0]        rgt;
        logic [12:0]        tp;
        logic [13:0]        btm;
        logic               lst;
    } bar_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] sample = '0;
    logic               frame_end = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = sbr_pkg::REG_WINDOW_LEN;
    logic [12:0]        cfg_data = '0;
    logic               strobe;
    logic [5:0]         bar_index;
    logic signed [15:0] level;
    logic [12:0]        left;
    logic [12:0]        right;
    logic [12:0]        top;
    logic [13:0]        bottom;
    logic               last_bar;

    word_t pend_words[$];
    bar_t  bars_due[$];
    int    n_err = 0;
    int    gap_left = 0;
    int    cyc = 0;

    logic signed [15:0] smp_mem [4096];
    logic [11:0]        wr_ptr = '0;
    int                 held = 0;
    int                 r_win = 1024, r_ax = 0, r_ay = 0, r_aw = 320, r_ah = 240;
    int                 r_bw = 4, r_bs = 1, r_mode = 0;

    scope_bar_resampler i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .sample(sample), .frame_end(frame_end),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .strobe(strobe), .bar_index(bar_index), .level(level),
        .left(left), .right(right), .top(top), .bottom(bottom),
        .last_bar(last_bar)
    );

    always #2 clk = ~clk;

    function automatic int window_at(int k, int w);
        int age;
        age = w - 1 - k;
        if (age >= held)
            return 0;
        return int'(smp_mem[(int'(wr_ptr) + 4095 - age) % 4096]);
    endfunction

    function automatic int floor_div(int num, int den);
        if (num >= 0)
            return num / den;
        return -((-num + den - 1) / den);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        if (r < 94)
            return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    task automatic predict_bars(logic signed [15:0] smp, logic fe);
        int pitch, cnt, w, centre, lvl, den, num, ix, rm, a, b, tgt, tp, btm, lft;
        bar_t bb;
        smp_mem[wr_ptr] = smp;
        wr_ptr = wr_ptr + 12'd1;
        if (held < 4096)
            held++;
        if (!fe)
            return;
        pitch = r_bw + r_bs;
        if (pitch == 0)
            return;
        cnt = r_aw / pitch;
        if (cnt > 64)
            cnt = 64;
        w = r_win < 1 ? 1 : (r_win > 4096 ? 4096 : r_win);
        centre = r_ay + (r_ah >> 1);
        for (int i = 0; i < cnt; i++) begin
            if (w == 1 || cnt == 1) begin
                lvl = window_at(0, w);
            end else begin
                den = cnt - 1;
                num = i * (w - 1);
                ix = num / den;
                rm = num % den;
                a = window_at(ix, w);
                b = (ix + 1 < w) ? window_at(ix + 1, w) : a;
                lvl = a + floor_div((b - a) * rm, den);
            end
            tgt = r_ay + ((r_ah * (32768 - lvl)) >>> 16);
            if (r_mode[0]) begin
                tp = tgt < centre ? tgt : centre;
                btm = tgt > centre ? tgt : centre;
            end else begin
                tp = tgt;
                btm = tgt + r_bw;
            end
            if (r_mode[1])
                lft = r_ax + r_aw - r_bw - i * pitch;
            else
                lft = r_ax + i * pitch;
            bb.idx = i[5:0];
            bb.lvl = lvl[15:0];
            bb.lft = lft[12:0];
            bb.rgt = 13'(lft + r_bw);
            bb.tp = tp[12:0];
            bb.btm = btm[13:0];
            bb.lst = (i + 1 == cnt);
            bars_due.push_back(bb);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (start && !busy)
                predict_bars(sample, frame_end);
            if (!(start && busy)) begin
                if (gap_left > 0) begin
                    start <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (pend_words.size() > 0) begin
                    sample <= pend_words[0].smp;
                    frame_end <= pend_words[0].fe;
                    void'(pend_words.pop_front());
                    start <= 1'b1;
                    gap_left <= pick_gap();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        bar_t e;
        if (rst_n && strobe) begin
            if (bars_due.size() == 0) begin
                $error("unexpected bar %0d", bar_index);
                n_err++;
            end else begin
                e = bars_due.pop_front();
                if (bar_index !== e.idx) begin
                    $error("bar_index exp %0d got %0d", e.idx, bar_index); n_err++;
                end
                if (level !== e.lvl) begin
                    $error("level exp %0d got %0d", e.lvl, level); n_err++;
                end
                if (left !== e.lft) begin
                    $error("left exp %0d got %0d", e.lft, left); n_err++;
                end
                if (right !== e.rgt) begin
                    $error("right exp %0d got %0d", e.rgt, right); n_err++;
                end
                if (top !== e.tp) begin
                    $error("top exp %0d got %0d", e.tp, top); n_err++;
                end
                if (bottom !== e.btm) begin
                    $error("bottom exp %0d got %0d", e.btm, bottom); n_err++;
                end
                if (last_bar !== e.lst) begin
                    $error("last_bar exp %0d got %0d", e.lst, last_bar); n_err++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc > 5000000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] ix, int val);
        @(posedge clk);
        cfg_index <= ix;
        cfg_data <= val[12:0];
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (ix)
            sbr_pkg::REG_WINDOW_LEN:  r_win = val & 13'h1FFF;
            sbr_pkg::REG_AREA_X:      r_ax = val & 12'hFFF;
            sbr_pkg::REG_AREA_Y:      r_ay = val & 12'hFFF;
            sbr_pkg::REG_AREA_WIDTH:  r_aw = val & 12'hFFF;
            sbr_pkg::REG_AREA_HEIGHT: r_ah = val & 12'hFFF;
            sbr_pkg::REG_BAR_WIDTH:   r_bw = val & 8'hFF;
            sbr_pkg::REG_BAR_SPACING: r_bs = val & 8'hFF;
            sbr_pkg::REG_MODE:        r_mode = val & 2'h3;
            default: ;
        endcase
    endtask

    task automatic push_word(int smp, logic fe);
        word_t wd;
        wd.smp = smp[15:0];
        wd.fe = fe;
        pend_words.push_back(wd);
    endtask

    task automatic drain();
        wait (pend_words.size() == 0 && !start && bars_due.size() == 0);
        repeat (400) @(posedge clk);
    endtask

    function automatic int rand_sample();
        case ($urandom_range(4))
            0: return -32768;
            1: return 32767;
            default: return $urandom_range(65535) - 32768;
        endcase
    endfunction

    task automatic random_config();
        case ($urandom_range(5))
            0: write_reg(sbr_pkg::REG_WINDOW_LEN, $urandom_range(2, 1));
            1: write_reg(sbr_pkg::REG_WINDOW_LEN, $urandom_range(64, 3));
            2: write_reg(sbr_pkg::REG_WINDOW_LEN, $urandom_range(4096, 65));
            3: write_reg(sbr_pkg::REG_WINDOW_LEN, $urandom_range(8191, 4097));
            default: write_reg(sbr_pkg::REG_WINDOW_LEN, $urandom_range(40, 0));
        endcase
        write_reg(sbr_pkg::REG_AREA_X, $urandom_range(4095));
        write_reg(sbr_pkg::REG_AREA_Y, $urandom_range(4095));
        write_reg(sbr_pkg::REG_AREA_WIDTH, $urandom_range(4095));
        write_reg(sbr_pkg::REG_AREA_HEIGHT, $urandom_range(4095));
        write_reg(sbr_pkg::REG_BAR_WIDTH, ($urandom_range(3) == 0) ? $urandom_range(255, 1)
                                                                   : $urandom_range(6, 1));
        write_reg(sbr_pkg::REG_BAR_SPACING, ($urandom_range(3) == 0) ? $urandom_range(255)
                                                                     : $urandom_range(3));
        write_reg(sbr_pkg::REG_MODE, $urandom_range(3));
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        push_word(-32768, 1'b0);
        push_word(32767, 1'b0);
        push_word(0, 1'b0);
        push_word(-1, 1'b0);
        push_word(1, 1'b1);
        drain();

        write_reg(sbr_pkg::REG_WINDOW_LEN, 1);
        write_reg(sbr_pkg::REG_AREA_WIDTH, 5);
        push_word(32767, 1'b1);
        drain();
        write_reg(sbr_pkg::REG_WINDOW_LEN, 0);
        write_reg(sbr_pkg::REG_AREA_WIDTH, 4095);
        write_reg(sbr_pkg::REG_MODE, 1);
        push_word(-32768, 1'b1);
        drain();

        write_reg(sbr_pkg::REG_BAR_WIDTH, 0);
        write_reg(sbr_pkg::REG_BAR_SPACING, 0);
        push_word(100, 1'b1);
        drain();
        write_reg(sbr_pkg::REG_BAR_WIDTH, 4);
        write_reg(sbr_pkg::REG_AREA_WIDTH, 3);
        push_word(-100, 1'b1);
        drain();

        write_reg(sbr_pkg::REG_WINDOW_LEN, 8191);
        write_reg(sbr_pkg::REG_AREA_X, 4095);
        write_reg(sbr_pkg::REG_AREA_Y, 4095);
        write_reg(sbr_pkg::REG_AREA_WIDTH, 4095);
        write_reg(sbr_pkg::REG_AREA_HEIGHT, 4095);
        write_reg(sbr_pkg::REG_BAR_WIDTH, 255);
        write_reg(sbr_pkg::REG_BAR_SPACING, 255);
        write_reg(sbr_pkg::REG_MODE, 3);
        push_word(32767, 1'b0);
        push_word(-32768, 1'b1);
        drain();
        write_reg(sbr_pkg::REG_BAR_WIDTH, 1);
        write_reg(sbr_pkg::REG_BAR_SPACING, 0);
        write_reg(sbr_pkg::REG_MODE, 2);
        push_word(12345, 1'b1);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            random_config();
            for (int k = 0; k < 25; k++)
                push_word(rand_sample(), ($urandom_range(5) == 0) || k == 24);
            drain();
        end

        if (n_err == 0 && bars_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
